[rtl/bgmb_pkg.sv]
// Shared types and constants for the bump gradient map builder.
// No dependencies; imported by every module of the block.
package bgmb_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SIZE_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RGBA_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE  = 3'd3;

  localparam logic [7:0] GRAD_ONE   = 8'd127;
  localparam logic [7:0] RGBA_BIAS  = 8'h80;
  localparam logic [7:0] RGBA_ALPHA = 8'hff;

  typedef enum logic {OP_LOAD = 1'b0, OP_READ = 1'b1} op_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] rgba_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] texel;
    logic        last;
    logic [7:0]  gradient_peak;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] height;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

[rtl/bump_gradient_map_builder_top.sv]
// Top level of the bump gradient map builder: front queue plus back end.
// Depends on bgmb_pkg, bgmb_front and bgmb_back.
// Load items are written to the height store by the back end; the last load starts
// a build pass: per texel, four height reads on the single store port plus the write.
// Read items hold the back end in S_RD_WAIT and, with scaling on, in the 14-step restoring
// divider; the result then strobes out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears control, registers to reset values, stores undefined.
module bump_gradient_map_builder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bgmb_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output bgmb_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgmb_pkg::SIZE_W-1:0]    cfg_data
);
  import bgmb_pkg::*;

  q_head_t head;
  logic    pop;

  // configuration is always taken; write only while no item is in flight
  assign cfg_ready = 1'b1;

  bgmb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  bgmb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/bgmb_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on bgmb_pkg.
module bgmb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bgmb_pkg::in_item_t in_item,
  output bgmb_pkg::q_head_t  head,
  input  logic              pop
);
  import bgmb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t            q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]      cnt_r;
  logic                push, do_pop;
  q_entry_t            new_entry;

  assign busy   = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    new_entry.op     = in_item.kind ? OP_READ : OP_LOAD;
    new_entry.height = in_item.rgba_word[15:8];
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

[rtl/bgmb_back.sv]
// Back end: height and gradient stores, build sequencer, normalizing divider.
// Depends on bgmb_pkg.
module bgmb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgmb_pkg::q_head_t             head,
  output logic                          pop,
  input  logic                          cfg_valid,
  input  logic [bgmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgmb_pkg::SIZE_W-1:0]    cfg_data,
  output logic                          out_valid,
  output bgmb_pkg::out_item_t           out_item
);
  import bgmb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BUILD, S_RD_WAIT, S_DIV} state_t;
  typedef enum logic {PH_LOAD, PH_READ} phase_t;

  state_t              state_r;
  phase_t              phase_r;
  logic [SIZE_W-1:0]   width_cfg_r, height_cfg_r;
  logic                rgba_r, norm_r;
  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [CNT_W-1:0]    total_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [7:0]          peak_r;

  logic [7:0]          hmem [MAX_WIDTH*MAX_HEIGHT];
  logic [15:0]         gmem [MAX_WIDTH*MAX_HEIGHT];
  logic [ADDR_W-1:0]   h_raddr;
  logic [7:0]          h_rdata_r;
  logic [15:0]         g_rdata_r;

  // build sequencer
  logic [CNT_W-1:0]    k_r, row_base_r;
  logic [SIZE_W-1:0]   x_r, y_r;
  logic [2:0]          step_r;
  logic [7:0]          hxr_r, hxl_r, hyu_r, bpeak_r;
  logic [7:0]          ds, dt, abs_s, abs_t, peak_nxt;
  logic [CNT_W-1:0]    a_xr, a_xl, a_yu, a_yd;

  // divider
  logic [DIV_STEPS-1:0] num_s_r, num_t_r, quo_s_r, quo_t_r;
  logic [7:0]          rem_s_r, rem_t_r;
  logic                neg_s_r, neg_t_r;
  logic [3:0]          it_r;
  logic [8:0]          trial_s, trial_t;
  logic                qb_s, qb_t;
  logic [7:0]          rem_s_nxt, rem_t_nxt, qs_fin, qt_fin;
  logic [7:0]          mag_s, mag_t;

  logic                out_valid_r;
  out_item_t           out_r;
  logic                last_tex;

  assign w_eff = (width_cfg_r == '0) ? SIZE_W'(1) :
                 (width_cfg_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_cfg_r;
  assign h_eff = (height_cfg_r == '0) ? SIZE_W'(1) :
                 (height_cfg_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_cfg_r;

  assign pop      = head.valid && (state_r == S_IDLE);
  assign last_tex = (cnt_r + 1'b1 == total_r);

  // neighbor addresses with wrap-around
  always_comb begin
    a_xr = (x_r + 1'b1 == w_eff) ? row_base_r : k_r + 1'b1;
    a_xl = (x_r == '0) ? row_base_r + CNT_W'(w_eff) - 1'b1 : k_r - 1'b1;
    a_yu = (y_r + 1'b1 == h_eff) ? CNT_W'(x_r) : k_r + CNT_W'(w_eff);
    a_yd = (y_r == '0) ? total_r - CNT_W'(w_eff) + CNT_W'(x_r) : k_r - CNT_W'(w_eff);
    case (step_r)
      3'd0:    h_raddr = a_xr[ADDR_W-1:0];
      3'd1:    h_raddr = a_xl[ADDR_W-1:0];
      3'd2:    h_raddr = a_yu[ADDR_W-1:0];
      default: h_raddr = a_yd[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ds       = hxr_r - hxl_r;
    dt       = hyu_r - h_rdata_r;
    abs_s    = ds[7] ? 8'(-ds) : ds;
    abs_t    = dt[7] ? 8'(-dt) : dt;
    peak_nxt = bpeak_r;
    if (abs_s > peak_nxt) peak_nxt = abs_s;
    if (abs_t > peak_nxt) peak_nxt = abs_t;
  end

  // one restoring step per lane
  always_comb begin
    trial_s   = {rem_s_r, num_s_r[DIV_STEPS-1]};
    trial_t   = {rem_t_r, num_t_r[DIV_STEPS-1]};
    qb_s      = (trial_s >= {1'b0, peak_r});
    qb_t      = (trial_t >= {1'b0, peak_r});
    rem_s_nxt = qb_s ? 8'(trial_s - {1'b0, peak_r}) : trial_s[7:0];
    rem_t_nxt = qb_t ? 8'(trial_t - {1'b0, peak_r}) : trial_t[7:0];
    qs_fin    = {quo_s_r[6:0], qb_s};
    qt_fin    = {quo_t_r[6:0], qb_t};
    mag_s     = g_rdata_r[7]  ? 8'(-g_rdata_r[7:0])  : g_rdata_r[7:0];
    mag_t     = g_rdata_r[15] ? 8'(-g_rdata_r[15:8]) : g_rdata_r[15:8];
  end

  function automatic logic [31:0] pack_texel(logic [7:0] s, logic [7:0] t, logic rgba);
    if (rgba) pack_texel = {RGBA_ALPHA, 8'h00, 8'(t + RGBA_BIAS), 8'(s + RGBA_BIAS)};
    else      pack_texel = {16'h0000, t, s};
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (pop && head.entry.op == OP_LOAD && phase_r == PH_LOAD) begin
      hmem[cnt_r[ADDR_W-1:0]] <= head.entry.height;
    end
    h_rdata_r <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BUILD && step_r == 3'd4) begin
      gmem[k_r[ADDR_W-1:0]] <= {dt, ds};
    end
    g_rdata_r <= gmem[cnt_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    total_r <= CNT_W'(w_eff * h_eff);
  end

  // datapath registers (no reset)
  always_ff @(posedge clk) begin
    case (step_r)
      3'd1:    hxr_r <= h_rdata_r;
      3'd2:    hxl_r <= h_rdata_r;
      3'd3:    hyu_r <= h_rdata_r;
      default: ;
    endcase
    if (state_r == S_RD_WAIT) begin
      num_s_r <= DIV_STEPS'(mag_s) * DIV_STEPS'(GRAD_ONE);
      num_t_r <= DIV_STEPS'(mag_t) * DIV_STEPS'(GRAD_ONE);
      neg_s_r <= g_rdata_r[7];
      neg_t_r <= g_rdata_r[15];
      rem_s_r <= '0;
      rem_t_r <= '0;
      quo_s_r <= '0;
      quo_t_r <= '0;
    end else if (state_r == S_DIV) begin
      num_s_r <= {num_s_r[DIV_STEPS-2:0], 1'b0};
      num_t_r <= {num_t_r[DIV_STEPS-2:0], 1'b0};
      rem_s_r <= rem_s_nxt;
      rem_t_r <= rem_t_nxt;
      quo_s_r <= {quo_s_r[DIV_STEPS-2:0], qb_s};
      quo_t_r <= {quo_t_r[DIV_STEPS-2:0], qb_t};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LOAD;
      cnt_r        <= '0;
      peak_r       <= '0;
      width_cfg_r  <= SIZE_W'(256);
      height_cfg_r <= SIZE_W'(256);
      rgba_r       <= 1'b0;
      norm_r       <= 1'b1;
      step_r       <= '0;
      k_r          <= '0;
      row_base_r   <= '0;
      x_r          <= '0;
      y_r          <= '0;
      bpeak_r      <= '0;
      it_r         <= '0;
      out_valid_r  <= 1'b0;
      out_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_index <= REG_NORMALIZE) begin
        case (cfg_index)
          REG_MAP_WIDTH:  width_cfg_r  <= cfg_data;
          REG_MAP_HEIGHT: height_cfg_r <= cfg_data;
          REG_RGBA_MODE:  rgba_r       <= cfg_data[0];
          default:        norm_r       <= cfg_data[0];
        endcase
        phase_r <= PH_LOAD;
        cnt_r   <= '0;
        state_r <= S_IDLE;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (pop && head.entry.op == OP_LOAD && phase_r == PH_LOAD) begin
              if (last_tex) begin
                cnt_r      <= '0;
                state_r    <= S_BUILD;
                step_r     <= '0;
                k_r        <= '0;
                row_base_r <= '0;
                x_r        <= '0;
                y_r        <= '0;
                bpeak_r    <= '0;
              end else begin
                cnt_r <= cnt_r + 1'b1;
              end
            end else if (pop && head.entry.op == OP_READ && phase_r == PH_READ) begin
              state_r <= S_RD_WAIT;
            end
          end
          S_BUILD: begin
            if (step_r != 3'd4) begin
              step_r <= step_r + 1'b1;
            end else begin
              step_r  <= '0;
              bpeak_r <= peak_nxt;
              if (k_r + 1'b1 == total_r) begin
                peak_r  <= peak_nxt;
                phase_r <= PH_READ;
                state_r <= S_IDLE;
              end else begin
                k_r <= k_r + 1'b1;
                if (x_r + 1'b1 == w_eff) begin
                  x_r        <= '0;
                  y_r        <= y_r + 1'b1;
                  row_base_r <= row_base_r + CNT_W'(w_eff);
                end else begin
                  x_r <= x_r + 1'b1;
                end
              end
            end
          end
          S_RD_WAIT: begin
            if (norm_r && peak_r != '0) begin
              state_r <= S_DIV;
              it_r    <= 4'(DIV_STEPS - 1);
            end else begin
              out_valid_r         <= 1'b1;
              out_r.texel         <= pack_texel(g_rdata_r[7:0], g_rdata_r[15:8], rgba_r);
              out_r.last          <= last_tex;
              out_r.gradient_peak <= GRAD_ONE;
              state_r             <= S_IDLE;
              cnt_r               <= last_tex ? '0 : cnt_r + 1'b1;
              if (last_tex) phase_r <= PH_LOAD;
            end
          end
          S_DIV: begin
            if (it_r != '0) begin
              it_r <= it_r - 1'b1;
            end else begin
              out_valid_r         <= 1'b1;
              out_r.texel         <= pack_texel(neg_s_r ? 8'(-qs_fin) : qs_fin,
                                                neg_t_r ? 8'(-qt_fin) : qt_fin, rgba_r);
              out_r.last          <= last_tex;
              out_r.gradient_peak <= peak_r;
              state_r             <= S_IDLE;
              cnt_r               <= last_tex ? '0 : cnt_r + 1'b1;
              if (last_tex) phase_r <= PH_LOAD;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_build_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BUILD |-> phase_r == PH_LOAD) else $error("build outside load phase");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_RD_WAIT || $past(state_r) == S_DIV))
    else $error("result without a read");
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= 8'd128) else $error("peak out of range");
  a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (norm_r && peak_r != '0)) else $error("divide without scaling");
`endif

endmodule
